/* rtl/bmpspu_pkg.sv */
// Shared types and constants for the BMP stream pixel unpacker.
`default_nettype none

package bmpspu_pkg;

    // Result kinds carried on the output tuser
    typedef enum logic [2:0] {
        ST_PIXEL      = 3'd0,
        ST_HEADER_OK  = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_BAD_INFO   = 3'd3,
        ST_BAD_DEPTH  = 3'd4,
        ST_TOO_LARGE  = 3'd5,
        ST_BAD_OFFSET = 3'd6
    } status_t;

    // Header layout: byte positions of the fields that are kept
    localparam logic [4:0] POS_MAGIC0 = 5'd0;
    localparam logic [4:0] POS_MAGIC1 = 5'd1;
    localparam logic [4:0] POS_OFFSET = 5'd10;
    localparam logic [4:0] POS_INFO   = 5'd14;
    localparam logic [4:0] POS_WIDTH  = 5'd18;
    localparam logic [4:0] POS_HEIGHT = 5'd22;
    localparam logic [4:0] POS_DEPTH  = 5'd28;
    localparam logic [4:0] POS_LAST   = 5'd29;

    localparam logic [7:0]  MAGIC_B    = 8'h42;
    localparam logic [7:0]  MAGIC_M    = 8'h4D;
    localparam logic [31:0] INFO_SIZE  = 32'd40;
    localparam logic [15:0] DEPTH_24   = 16'd24;
    localparam logic [15:0] DEPTH_32   = 16'd32;
    localparam logic [31:0] HDR_BYTES  = 32'd30;
    localparam logic [7:0]  BPP_3      = 8'd3;
    localparam logic [7:0]  BPP_4      = 8'd4;

endpackage

`default_nettype wire

/* rtl/bmp_stream_pixel_unpacker_top.sv */
// Top level of the BMP stream pixel unpacker: header parse, skip, pixel unpack.
`default_nettype none

// The block takes a BMP file one byte per item (s_axis_tuser high on the first
// byte of a file restarts parsing) and gathers the first 30 bytes as header
// fields. On byte 29 it checks magic 'BM', info size 40, depth 24 or 32, width
// and height against 2^DIM_BITS-1 and pixel offset against 30, in that order,
// and emits one header or error item (status on m_axis_tuser). After a good
// header it skips to the pixel offset and emits one item per pixel byte with
// RGB(A) channel, column and top-down row; row padding yields no item.
// Errors, a header with zero width or height, and the final pixel byte
// carry tlast; later bytes are dropped until the next start of file.
// Rate: one byte per clock unless the output stalls; the combinational parser
// feeds the output register; input is ready while it is empty or draining.
module bmp_stream_pixel_unpacker_top #(
    parameter int DIM_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_axis_tdata [7:0] byte_value
    input  wire logic [7:0]  s_axis_tdata,
    // s_axis_tuser [0] start_of_file
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // m_axis_tdata [1:0] channel, [17:2] pixel_x, [33:18] pixel_y,
    // [41:34] value, [47:42] zero
    output logic [47:0]      m_axis_tdata,
    // m_axis_tuser [2:0] status
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } phase_t;

    // Largest legal width or height
    localparam logic [32:0] DIM_LIMIT = (33'd1 << DIM_BITS) - 33'd1;

    phase_t                phase_reg, phase_next;
    logic [4:0]            hdr_cnt_reg, hdr_cnt_next;
    logic                  magic_ok_reg, magic_ok_next;
    logic [31:0]           offset_reg, offset_next;
    logic [31:0]           info_reg, info_next;
    logic [31:0]           width_reg, width_next;
    logic [31:0]           height_reg, height_next;
    logic [15:0]           depth_reg, depth_next;
    logic [31:0]           skip_reg, skip_next;
    logic [1:0]            bip_reg, bip_next;
    logic [DIM_BITS-1:0]   column_reg, column_next;
    logic [DIM_BITS-1:0]   row_reg, row_next;
    logic [1:0]            pad_reg, pad_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    bmpspu_pkg::status_t   out_status_reg, out_status_next;
    logic [1:0]            out_channel_reg, out_channel_next;
    logic [15:0]           out_x_reg, out_x_next;
    logic [15:0]           out_y_reg, out_y_next;
    logic [7:0]            out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;

    // Result of the byte at the input
    logic                  res_valid;
    bmpspu_pkg::status_t   res_status;
    logic [1:0]            res_channel;
    logic [15:0]           res_x;
    logic [15:0]           res_y;
    logic [7:0]            res_value;
    logic                  res_last;

    logic                  accept;
    phase_t                phase_cur;
    logic [4:0]            hdr_cnt_cur;
    logic                  magic_cur;
    logic [4:0]            rel_offset, rel_info, rel_width, rel_height, rel_depth;
    logic [15:0]           depth_now;
    bmpspu_pkg::status_t   check_status;
    logic                  bpp4;
    logic [1:0]            bpp_m1;
    logic [DIM_BITS-1:0]   width_dim, height_dim;
    logic [DIM_BITS-1:0]   column_inc, row_inc, y_dim;
    logic [31:0]           column_32, y_32;
    logic [31:0]           skip_dec;
    logic [1:0]            pad_dec;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Start of file overrides the parse position
    assign phase_cur   = s_axis_tuser ? PH_HEADER : phase_reg;
    assign hdr_cnt_cur = s_axis_tuser ? '0 : hdr_cnt_reg;
    assign magic_cur   = s_axis_tuser ? 1'b1 : magic_ok_reg;

    assign rel_offset = hdr_cnt_cur - bmpspu_pkg::POS_OFFSET;
    assign rel_info   = hdr_cnt_cur - bmpspu_pkg::POS_INFO;
    assign rel_width  = hdr_cnt_cur - bmpspu_pkg::POS_WIDTH;
    assign rel_height = hdr_cnt_cur - bmpspu_pkg::POS_HEIGHT;
    assign rel_depth  = hdr_cnt_cur - bmpspu_pkg::POS_DEPTH;

    // Depth as seen on the closing header byte (its upper byte arrives now)
    assign depth_now = {s_axis_tdata, depth_reg[7:0]};

    always_comb
    begin
        if (!magic_cur)
            check_status = bmpspu_pkg::ST_BAD_MAGIC;
        else if (info_reg != bmpspu_pkg::INFO_SIZE)
            check_status = bmpspu_pkg::ST_BAD_INFO;
        else if (depth_now != bmpspu_pkg::DEPTH_24 && depth_now != bmpspu_pkg::DEPTH_32)
            check_status = bmpspu_pkg::ST_BAD_DEPTH;
        else if ({1'b0, width_reg} > DIM_LIMIT || {1'b0, height_reg} > DIM_LIMIT)
            check_status = bmpspu_pkg::ST_TOO_LARGE;
        else if (offset_reg < bmpspu_pkg::HDR_BYTES)
            check_status = bmpspu_pkg::ST_BAD_OFFSET;
        else
            check_status = bmpspu_pkg::ST_HEADER_OK;
    end

    // Pixel geometry; dimensions fit DIM_BITS once the header has passed
    assign bpp4       = (depth_reg == bmpspu_pkg::DEPTH_32);
    assign bpp_m1     = bpp4 ? 2'd3 : 2'd2;
    assign width_dim  = width_reg[DIM_BITS-1:0];
    assign height_dim = height_reg[DIM_BITS-1:0];
    assign column_inc = column_reg + 1'b1;
    assign row_inc    = row_reg + 1'b1;
    assign y_dim      = height_dim - row_reg - 1'b1;
    assign column_32  = 32'(column_reg);
    assign y_32       = 32'(y_dim);
    assign skip_dec   = skip_reg - 32'd1;
    assign pad_dec    = pad_reg - 2'd1;

    always_comb
    begin
        phase_next    = phase_cur;
        hdr_cnt_next  = hdr_cnt_cur;
        magic_ok_next = magic_cur;
        offset_next   = offset_reg;
        info_next     = info_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        skip_next     = skip_reg;
        bip_next      = bip_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        pad_next      = pad_reg;

        res_valid   = 1'b0;
        res_status  = bmpspu_pkg::ST_PIXEL;
        res_channel = '0;
        res_x       = '0;
        res_y       = '0;
        res_value   = '0;
        res_last    = 1'b0;

        case (phase_cur)
            PH_HEADER:
            begin
                if (hdr_cnt_cur == bmpspu_pkg::POS_MAGIC0 && s_axis_tdata != bmpspu_pkg::MAGIC_B)
                    magic_ok_next = 1'b0;
                if (hdr_cnt_cur == bmpspu_pkg::POS_MAGIC1 && s_axis_tdata != bmpspu_pkg::MAGIC_M)
                    magic_ok_next = 1'b0;
                if (rel_offset < 5'd4)
                    offset_next[8*rel_offset[1:0] +: 8] = s_axis_tdata;
                if (rel_info < 5'd4)
                    info_next[8*rel_info[1:0] +: 8] = s_axis_tdata;
                if (rel_width < 5'd4)
                    width_next[8*rel_width[1:0] +: 8] = s_axis_tdata;
                if (rel_height < 5'd4)
                    height_next[8*rel_height[1:0] +: 8] = s_axis_tdata;
                if (rel_depth < 5'd2)
                    depth_next[8*rel_depth[0] +: 8] = s_axis_tdata;

                if (hdr_cnt_cur >= bmpspu_pkg::POS_LAST)
                begin
                    hdr_cnt_next = '0;
                    res_valid    = 1'b1;
                    res_status   = check_status;
                    if (check_status != bmpspu_pkg::ST_HEADER_OK)
                    begin
                        phase_next = PH_DONE;
                        res_last   = 1'b1;
                    end
                    else
                    begin
                        bip_next    = '0;
                        column_next = '0;
                        row_next    = '0;
                        pad_next    = '0;
                        res_x       = width_reg[15:0];
                        res_y       = height_reg[15:0];
                        res_value   = (depth_now == bmpspu_pkg::DEPTH_32) ?
                                      bmpspu_pkg::BPP_4 : bmpspu_pkg::BPP_3;
                        if (width_reg == '0 || height_reg == '0)
                        begin
                            phase_next = PH_DONE;
                            res_last   = 1'b1;
                        end
                        else
                        begin
                            skip_next  = offset_reg - bmpspu_pkg::HDR_BYTES;
                            phase_next = (offset_reg == bmpspu_pkg::HDR_BYTES) ?
                                         PH_PIXEL : PH_SKIP;
                        end
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_cur + 5'd1;
                end
            end

            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                    phase_next = PH_PIXEL;
            end

            PH_PAD:
            begin
                pad_next = pad_dec;
                if (pad_dec == '0)
                    phase_next = PH_PIXEL;
            end

            PH_PIXEL:
            begin
                res_valid   = 1'b1;
                res_status  = bmpspu_pkg::ST_PIXEL;
                res_channel = bpp_m1 - bip_reg;
                res_x       = column_32[15:0];
                res_y       = y_32[15:0];
                res_value   = s_axis_tdata;
                bip_next    = bip_reg + 2'd1;
                if (bip_reg == bpp_m1)
                begin
                    bip_next    = '0;
                    column_next = column_inc;
                    if (column_inc == width_dim)
                    begin
                        column_next = '0;
                        row_next    = row_inc;
                        if (row_inc == height_dim)
                        begin
                            res_last   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (!bpp4 && width_reg[1:0] != 2'd0)
                        begin
                            // 24-bit rows pad by width mod 4 bytes
                            pad_next   = width_reg[1:0];
                            phase_next = PH_PAD;
                        end
                    end
                end
            end

            default:
            begin
                // Drop bytes until the next start of file
                phase_next = PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_channel_next = out_channel_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_value_next   = out_value_reg;
        out_last_next    = out_last_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_status_next  = res_status;
                out_channel_next = res_channel;
                out_x_next       = res_x;
                out_y_next       = res_y;
                out_value_next   = res_value;
                out_last_next    = res_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            hdr_cnt_reg     <= '0;
            magic_ok_reg    <= 1'b1;
            offset_reg      <= '0;
            info_reg        <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            depth_reg       <= '0;
            skip_reg        <= '0;
            bip_reg         <= '0;
            column_reg      <= '0;
            row_reg         <= '0;
            pad_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= bmpspu_pkg::ST_PIXEL;
            out_channel_reg <= '0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_value_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                hdr_cnt_reg  <= hdr_cnt_next;
                magic_ok_reg <= magic_ok_next;
                offset_reg   <= offset_next;
                info_reg     <= info_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                depth_reg    <= depth_next;
                skip_reg     <= skip_next;
                bip_reg      <= bip_next;
                column_reg   <= column_next;
                row_reg      <= row_next;
                pad_reg      <= pad_next;
            end
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_channel_reg <= out_channel_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_value_reg   <= out_value_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_value_reg, out_y_reg, out_x_reg, out_channel_reg};

    // A closing item always parks the parser until the next file
    a_last_parks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && res_last |=> phase_reg == PH_DONE)
        else $error("closing item did not park the parser");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != '0)
        else $error("skip phase with nothing left to skip");

    a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD |-> pad_reg != '0)
        else $error("pad phase with no padding left");

    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= bmpspu_pkg::POS_LAST)
        else $error("header byte count ran past the header");

endmodule

`default_nettype wire
